@@ sv/mrs_pkg.sv @@
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared types and constants for the modular square and root search block.
// ----------------------------------------------------------------------------
package mrs_pkg;

	localparam int VALUE_W   = 16;
	localparam int PROD_W    = 2 * VALUE_W;
	localparam int RED_CNT_W = $clog2(PROD_W);

	localparam logic FUNC_ENCRYPT = 1'b0;
	localparam logic FUNC_DECRYPT = 1'b1;

	typedef struct packed {
		logic               func;
		logic [VALUE_W-1:0] operand;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] result_value;
		logic               found;
		logic               truncated;
		logic               last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENC_MUL,
		ST_ENC_RED,
		ST_ENC_OUT,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef enum logic [1:0] {
		EMIT_ENC,
		EMIT_PEND,
		EMIT_NONE
	} emit_sel_t;

	typedef struct packed {
		logic      load;
		logic      mul_en;
		logic      red_en;
		logic      scan_adv;
		logic      root_take;
		logic      emit;
		emit_sel_t emit_sel;
		logic      emit_trunc;
		logic      emit_last;
	} mrs_cmd_t;

	typedef struct packed {
		logic out_free;
		logic scan_done;
		logic match;
		logic at_limit;
		logic pend_vld;
		logic red_done;
	} mrs_status_t;

endpackage

@@ sv/mrs_datapath.sv @@
// ----------------------------------------------------------------------------
// mrs_datapath
// Modulus register, shift-subtract reducer for squaring, incremental square
// tracker for the root scan, held root and output register.
// ----------------------------------------------------------------------------
module mrs_datapath
	import mrs_pkg::*;
#(
	parameter int MAX_ROOTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [VALUE_W-1:0] cfg_wdata,
	input  in_item_t           in_data,
	input  mrs_cmd_t           cmd,
	output mrs_status_t        status,
	input  logic               out_ready,
	output logic               out_valid,
	output out_item_t          out_data
);

	localparam int CNT_W = $clog2(MAX_ROOTS + 1);

	logic [VALUE_W-1:0] mod_q;
	logic [VALUE_W-1:0] n_eff;
	logic [VALUE_W-1:0] idx_q;
	logic [VALUE_W-1:0] sq_q;
	logic [VALUE_W-1:0] d_q;
	logic [VALUE_W-1:0] tgt_q;
	logic [VALUE_W-1:0] pend_q;
	logic               pend_vld_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PROD_W-1:0]  prod_q;
	logic [VALUE_W-1:0] red_q;
	logic [RED_CNT_W-1:0] bit_q;
	logic               out_vld_q;
	out_item_t          out_q;
	out_item_t          out_nx;

	logic [VALUE_W:0]   n_ext;
	logic [VALUE_W:0]   red_sh;
	logic [VALUE_W:0]   red_nx;
	logic [VALUE_W:0]   sq_sum;
	logic [VALUE_W:0]   sq_nx;
	logic [VALUE_W:0]   d_p2;
	logic [VALUE_W:0]   d_r1;
	logic [VALUE_W:0]   d_r2;
	logic [VALUE_W-1:0] d_init;

	// A modulus of zero behaves as a modulus of one.
	assign n_eff  = (mod_q == '0) ? VALUE_W'(1) : mod_q;
	assign n_ext  = {1'b0, n_eff};
	assign d_init = (n_eff == VALUE_W'(1)) ? '0 : VALUE_W'(1);

	// One bit of the product enters the remainder each step; it stays below 2n.
	assign red_sh = {red_q, prod_q[PROD_W-1]};
	assign red_nx = (red_sh >= n_ext) ? red_sh - n_ext : red_sh;

	// (i+1)^2 = i^2 + (2i+1): both terms are kept reduced modulo n.
	assign sq_sum = {1'b0, sq_q} + {1'b0, d_q};
	assign sq_nx  = (sq_sum >= n_ext) ? sq_sum - n_ext : sq_sum;
	assign d_p2   = {1'b0, d_q} + (VALUE_W+1)'(2);
	assign d_r1   = (d_p2 >= n_ext) ? d_p2 - n_ext : d_p2;
	assign d_r2   = (d_r1 >= n_ext) ? d_r1 - n_ext : d_r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q      <= VALUE_W'(1);
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				mod_q <= cfg_wdata;
			end
			if (cmd.load) begin
				pend_vld_q <= 1'b0;
			end else if (cmd.root_take) begin
				pend_vld_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tgt_q <= in_data.operand;
			idx_q <= '0;
			sq_q  <= '0;
			d_q   <= d_init;
			cnt_q <= '0;
			red_q <= '0;
			bit_q <= '0;
		end else begin
			if (cmd.scan_adv) begin
				idx_q <= idx_q + VALUE_W'(1);
				sq_q  <= sq_nx[VALUE_W-1:0];
				d_q   <= d_r2[VALUE_W-1:0];
			end
			if (cmd.root_take) begin
				pend_q <= idx_q;
				cnt_q  <= cnt_q + CNT_W'(1);
			end
			if (cmd.red_en) begin
				red_q  <= red_nx[VALUE_W-1:0];
				prod_q <= {prod_q[PROD_W-2:0], 1'b0};
				bit_q  <= bit_q + RED_CNT_W'(1);
			end
		end
		if (cmd.mul_en) begin
			prod_q <= PROD_W'(tgt_q) * PROD_W'(tgt_q);
		end
		if (cmd.emit) begin
			out_q <= out_nx;
		end
	end

	always_comb begin
		out_nx.truncated = cmd.emit_trunc;
		out_nx.last      = cmd.emit_last;
		case (cmd.emit_sel)
			EMIT_ENC: begin
				out_nx.result_value = red_q;
				out_nx.found        = 1'b1;
			end
			EMIT_PEND: begin
				out_nx.result_value = pend_q;
				out_nx.found        = 1'b1;
			end
			default: begin
				out_nx.result_value = '0;
				out_nx.found        = 1'b0;
			end
		endcase
	end

	assign status.out_free  = !out_vld_q || out_ready;
	assign status.scan_done = (idx_q == n_eff);
	assign status.match     = (sq_q == tgt_q);
	assign status.at_limit  = (cnt_q == CNT_W'(MAX_ROOTS - 1));
	assign status.pend_vld  = pend_vld_q;
	assign status.red_done  = (bit_q == RED_CNT_W'(PROD_W - 1));

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

@@ sv/mrs_controller.sv @@
// ----------------------------------------------------------------------------
// mrs_controller
// Sequencer for encrypt (multiply, reduce, emit) and decrypt (root scan).
// ----------------------------------------------------------------------------
module mrs_controller
	import mrs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_func,
	output logic        in_ready,
	input  mrs_status_t status,
	output mrs_cmd_t    cmd
);

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx       = state_q;
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.emit_sel   = EMIT_NONE;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = (in_func == FUNC_DECRYPT) ? ST_SCAN : ST_ENC_MUL;
				end
			end
			ST_ENC_MUL: begin
				cmd.mul_en = 1'b1;
				state_nx   = ST_ENC_RED;
			end
			ST_ENC_RED: begin
				cmd.red_en = 1'b1;
				if (status.red_done) begin
					state_nx = ST_ENC_OUT;
				end
			end
			ST_ENC_OUT: begin
				if (status.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = EMIT_ENC;
					cmd.emit_last = 1'b1;
					state_nx      = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (status.out_free) begin
					if (status.scan_done) begin
						cmd.emit      = 1'b1;
						cmd.emit_sel  = status.pend_vld ? EMIT_PEND : EMIT_NONE;
						cmd.emit_last = 1'b1;
						state_nx      = ST_IDLE;
					end else if (status.match) begin
						// The held root goes out now that a later one exists.
						cmd.emit      = status.pend_vld;
						cmd.emit_sel  = EMIT_PEND;
						cmd.root_take = 1'b1;
						if (status.at_limit) begin
							state_nx = ST_FLUSH;
						end else begin
							cmd.scan_adv = 1'b1;
						end
					end else begin
						cmd.scan_adv = 1'b1;
					end
				end
			end
			ST_FLUSH: begin
				if (status.out_free) begin
					cmd.emit       = 1'b1;
					cmd.emit_sel   = EMIT_PEND;
					cmd.emit_trunc = 1'b1;
					cmd.emit_last  = 1'b1;
					state_nx       = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

@@ sv/modular_square_and_root_search.sv @@
// Encrypt: a multiply step and a shift-subtract reduction of the product follow the
// accept; the result is then loaded into the output register when it is free.
// Decrypt: one candidate per cycle, from 0 up to modulus n - 1; the scan pauses while
// a result is stalled, and at the root limit the final root is emitted from the
// flush state.
// Reset is asynchronous, active low; the modulus returns to 1 and the block idles.
// ----------------------------------------------------------------------------
// modular_square_and_root_search
// Modular squaring and exhaustive modular square-root search over a
// configured modulus.
// ----------------------------------------------------------------------------
module modular_square_and_root_search
	import mrs_pkg::*;
#(
	parameter int MAX_ROOTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [VALUE_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_item_t           in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_item_t          out_data
);

	mrs_cmd_t    cmd;
	mrs_status_t status;

	mrs_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_func  (in_data.func),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	mrs_datapath #(
		.MAX_ROOTS (MAX_ROOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

@@ sv/mrs_checker.sv @@
// ----------------------------------------------------------------------------
// mrs_checker
// Port-level checks on the result stream of the block.
// ----------------------------------------------------------------------------
module mrs_checker
	import mrs_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input out_item_t          out_data
);

	// One item is worked on at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while a previous item is still in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// A no-root result is alone and carries a zero value.
	a_no_root_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |->
			out_data.last && !out_data.truncated && (out_data.result_value == '0))
		else $error("malformed no-root result");

	a_trunc_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.truncated |-> out_data.last && out_data.found)
		else $error("truncated flag on a result that is not the final root");

endmodule

bind modular_square_and_root_search mrs_checker u_mrs_checker (.*);

@@ verif/tb_modular_square_and_root_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_square_and_root_search
// Drives encrypt and decrypt items over several moduli with random idling on
// both channels and checks every result against a squaring and root-search
// predictor kept in a small scoreboard.
// ----------------------------------------------------------------------------
module tb_modular_square_and_root_search;
	import mrs_pkg::*;

	localparam int MAX_ROOTS      = 64;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int SETTLE_CYCLES  = 100;
	localparam int RANDOM_PHASES  = 6;
	localparam int PHASE_ITEMS    = 14;
	localparam int REPORT_CAP     = 50;

	class rabin_scoreboard;
		logic [VALUE_W-1:0] modulus;
		out_item_t          awaited_results[$];
		int unsigned        errors;

		function new();
			modulus = 1;
			errors  = 0;
		endfunction

		// Squares the plaintext, or lists the roots of the ciphertext in ascending order, up to MAX_ROOTS of them.
		function void note_request(in_item_t req);
			longint unsigned n;
			longint unsigned cand;
			longint unsigned sq;
			int              roots;
			out_item_t       res;
			n = (modulus == 0) ? 1 : modulus;
			if (req.func == FUNC_ENCRYPT) begin
				sq = req.operand;
				sq = (sq * sq) % n;
				res = '{sq[VALUE_W-1:0], 1'b1, 1'b0, 1'b1};
				awaited_results.insert(awaited_results.size(), res);
				return;
			end
			roots = 0;
			for (cand = 0; cand < n; cand++) begin
				if ((cand * cand) % n == req.operand) begin
					roots++;
					res = '{cand[VALUE_W-1:0], 1'b1, roots == MAX_ROOTS, 1'b0};
					awaited_results.insert(awaited_results.size(), res);
					if (roots == MAX_ROOTS)
						break;
				end
			end
			if (roots == 0) begin
				res = '{'0, 1'b0, 1'b0, 1'b1};
				awaited_results.insert(awaited_results.size(), res);
			end else begin
				awaited_results[awaited_results.size() - 1].last = 1'b1;
			end
		endfunction

		function void report(string what, longint unsigned want, longint unsigned got);
			errors++;
			if (errors <= REPORT_CAP)
				$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (awaited_results.size() == 0) begin
				report("unexpected result, items awaited", 0, 1);
				return;
			end
			want = awaited_results.pop_front();
			if (got.result_value !== want.result_value)
				report("result_value", want.result_value, got.result_value);
			if (got.found !== want.found)
				report("found", want.found, got.found);
			if (got.truncated !== want.truncated)
				report("truncated", want.truncated, got.truncated);
			if (got.last !== want.last)
				report("last", want.last, got.last);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [VALUE_W-1:0] cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_ready;
	out_item_t          out_data;

	int unsigned gap_odds     = 4;
	int unsigned stall_odds   = 4;
	int unsigned holds_wanted = 0;
	int unsigned holds_done   = 0;
	int unsigned quiet_cycles = 0;
	int unsigned composite_moduli [6] = '{15, 105, 1155, 2310, 4095, 15015};

	rabin_scoreboard sb = new();

	modular_square_and_root_search #(
		.MAX_ROOTS(MAX_ROOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Handshakes are sampled at the falling edge, where all signals are settled;
	// the item then moves at the following rising edge.
	always @(negedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
			sb.check_result(out_data);
		if ((in_valid === 1'b1 && in_ready === 1'b1) ||
				(out_valid === 1'b1 && out_ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin : result_sink
		out_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (holds_done != holds_wanted) begin
				holds_done++;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_item(input logic func, input logic [VALUE_W-1:0] operand);
		in_item_t req;
		req.func    = func;
		req.operand = operand;
		in_valid <= 1'b1;
		in_data  <= req;
		do @(negedge clk); while (in_ready !== 1'b1);
		@(posedge clk);
		sb.note_request(req);
		if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.awaited_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_modulus(input logic [VALUE_W-1:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.modulus = value;
	endtask

	// Most decrypt items carry a true square so that the search finds roots.
	task automatic random_item();
		int unsigned        n;
		longint unsigned    root;
		logic [VALUE_W-1:0] operand;
		n = (sb.modulus == 0) ? 1 : sb.modulus;
		operand = VALUE_W'($urandom());
		if ($urandom_range(0, 1) == 0) begin
			send_item(FUNC_ENCRYPT, operand);
		end else begin
			case ($urandom_range(0, 9))
				0: ;
				1: operand = VALUE_W'($urandom_range(0, n - 1));
				default: begin
					root    = $urandom_range(0, n - 1);
					operand = VALUE_W'((root * root) % n);
				end
			endcase
			send_item(FUNC_DECRYPT, operand);
		end
	endtask

	task automatic random_phase(input bit last_phase, input bit long_hold);
		logic [VALUE_W-1:0] m;
		case ($urandom_range(0, 3))
			0: m = VALUE_W'($urandom_range(2, 64));
			1: m = VALUE_W'($urandom_range(65, 600));
			2: m = VALUE_W'(composite_moduli[$urandom_range(0, 5)]);
			default: m = VALUE_W'($urandom_range(600, 3000));
		endcase
		set_modulus(m);
		if (last_phase) begin
			gap_odds   = 0;
			stall_odds = 0;
		end else begin
			gap_odds   = $urandom_range(0, 2) * 4;
			stall_odds = $urandom_range(0, 2) * 4;
		end
		if (long_hold)
			holds_wanted++;
		repeat (PHASE_ITEMS) random_item();
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Modulus 1 after reset: every square is 0 and only 0 has a root.
		send_item(FUNC_ENCRYPT, 16'd0);
		send_item(FUNC_ENCRYPT, 16'hFFFF);
		send_item(FUNC_DECRYPT, 16'd0);
		send_item(FUNC_DECRYPT, 16'd1);
		send_item(FUNC_DECRYPT, 16'hFFFF);

		// Largest modulus; the last ciphertext equals the modulus and has no root.
		set_modulus(16'hFFFF);
		send_item(FUNC_ENCRYPT, 16'd0);
		send_item(FUNC_ENCRYPT, 16'hFFFF);
		send_item(FUNC_ENCRYPT, 16'hAAAA);
		send_item(FUNC_ENCRYPT, 16'h5555);
		send_item(FUNC_DECRYPT, 16'd1);
		send_item(FUNC_DECRYPT, 16'hFFFF);

		// Zero has exactly the root limit of roots here, so the limit hits on the final one.
		set_modulus(16'd4096);
		send_item(FUNC_DECRYPT, 16'd0);
		send_item(FUNC_DECRYPT, 16'd1);
		send_item(FUNC_DECRYPT, 16'd2);
		send_item(FUNC_ENCRYPT, 16'd4097);

		// Zero has twice the root limit of roots here, so the scan stops early.
		set_modulus(16'd16384);
		send_item(FUNC_DECRYPT, 16'd0);
		send_item(FUNC_DECRYPT, 16'd16384);

		set_modulus(16'd1);
		send_item(FUNC_DECRYPT, 16'd0);
		send_item(FUNC_ENCRYPT, 16'd12345);

		for (int p = 0; p < RANDOM_PHASES; p++)
			random_phase(p == RANDOM_PHASES - 1, p == 0);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.awaited_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/mrs_pkg.sv
sv/mrs_datapath.sv
sv/mrs_controller.sv
sv/modular_square_and_root_search.sv
sv/mrs_checker.sv
verif/tb_modular_square_and_root_search.sv
